// ----- rtl/textured_span_rasterizer_macros.svh -----
// ----------------------------------------------------------------------------
// Textured span rasterizer assertion macros
// Shared property shapes for the port checker.
// ----------------------------------------------------------------------------
`ifndef TEXTURED_SPAN_RASTERIZER_MACROS_SVH
`define TEXTURED_SPAN_RASTERIZER_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define TRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: property failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define TRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: property failed");

`endif

// ----- rtl/trs_pkg.sv -----
// ----------------------------------------------------------------------------
// trs_pkg
// Types, codes and constants shared by the textured span rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package trs_pkg;

    // default geometry
    localparam int PLANE_BYTES_DEF = 16000;
    localparam int ROW_BYTES_DEF   = 80;
    localparam int SHADE_MAPS_DEF  = 33;

    localparam int TEX_DEPTH   = 4096;
    localparam int TEX_AW      = 12;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // detail mode codes
    localparam logic [1:0] DETAIL_HIGH = 2'd0;
    localparam logic [1:0] DETAIL_LOW  = 2'd2;

    typedef enum logic [1:0] {
        CMD_LOAD_TEXEL = 2'd0,
        CMD_LOAD_SHADE = 2'd1,
        CMD_BEGIN_SPAN = 2'd2,
        CMD_STEP_PIXEL = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        CFG_DETAIL_MODE  = 3'd0,
        CFG_WINDOW_LEFT  = 3'd1,
        CFG_WINDOW_TOP   = 3'd2,
        CFG_VIEW_COLUMNS = 3'd3,
        CFG_VIEW_ROWS    = 3'd4
    } cfg_reg_t;

    // work kinds passed from front to back
    typedef enum logic [1:0] {
        OP_TEX_WR   = 2'd0,
        OP_SHADE_WR = 2'd1,
        OP_ERROR    = 2'd2,
        OP_PIXEL    = 2'd3
    } op_kind_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [13:0] load_addr;
        logic [7:0]  load_byte;
        logic [8:0]  span_start;
        logic [8:0]  span_end;
        logic [7:0]  span_row;
        logic [31:0] u_start;
        logic [31:0] v_start;
        logic [31:0] u_step;
        logic [31:0] v_step;
        logic [5:0]  light_level;
    } request_t;

    typedef struct packed {
        logic [15:0] pixel_addr;
        logic [7:0]  pixel_value;
        logic        span_last;
        logic        span_error;
    } result_t;

    typedef struct packed {
        op_kind_t    kind;
        logic [13:0] mem_addr;    // texel index or shade table index
        logic [7:0]  data;        // load byte
        logic [5:0]  light;       // shade map of the pixel
        logic [15:0] pixel_addr;
        logic        last;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

// ----- rtl/trs_front.sv -----
// ----------------------------------------------------------------------------
// trs_front
// Configuration registers, span state and per-item classification.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_front #(
    parameter int PLANE_BYTES = trs_pkg::PLANE_BYTES_DEF,
    parameter int ROW_BYTES   = trs_pkg::ROW_BYTES_DEF,
    parameter int SHADE_MAPS  = trs_pkg::SHADE_MAPS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [8:0]        cfg_data,
    input  wire logic              push,
    input  wire trs_pkg::request_t request,
    input  wire logic              q_full,
    output logic                   enq_valid,
    output trs_pkg::op_t           enq_op
);
    import trs_pkg::*;

    localparam int          SHADE_DEPTH = SHADE_MAPS * 256;
    localparam logic [5:0]  LIGHT_MAX   = 6'(SHADE_MAPS - 1);
    localparam logic [15:0] PLANE_OFF_1 = 16'(PLANE_BYTES);
    localparam logic [15:0] PLANE_OFF_2 = 16'(2 * PLANE_BYTES);
    localparam logic [15:0] PLANE_OFF_3 = 16'(3 * PLANE_BYTES);

    logic [1:0]  detail_mode_reg;
    logic [8:0]  window_left_reg;
    logic [7:0]  window_top_reg;
    logic [8:0]  view_columns_reg;
    logic [7:0]  view_rows_reg;

    logic [31:0] u_acc_reg, u_acc_next;
    logic [31:0] v_acc_reg, v_acc_next;
    logic [11:0] column_reg, column_next;
    logic [8:0]  pixels_left_reg, pixels_left_next;
    logic [5:0]  light_reg, light_next;
    logic        active_reg, active_next;
    logic [15:0] row_base_reg, row_base_next;
    logic        col_dbl_reg, col_dbl_next;

    logic        accept;
    logic        cols_dbl, rows_dbl;
    logic        bad_bounds;
    logic [9:0]  frame_row;
    logic [5:0]  light_sat;
    logic        last;
    logic [15:0] plane_off;
    logic [11:0] texel_idx;

    assign accept   = push && !q_full;
    assign cols_dbl = detail_mode_reg != DETAIL_HIGH;
    assign rows_dbl = detail_mode_reg >= DETAIL_LOW;

    assign bad_bounds = ({1'b0, view_columns_reg} + 10'd1) < {1'b0, request.span_end}
                     || request.span_end <= request.span_start
                     || view_rows_reg <= request.span_row;

    assign frame_row = (rows_dbl ? {1'b0, request.span_row, 1'b0} : {2'b0, request.span_row})
                     + {2'b0, window_top_reg};

    assign light_sat = ({1'b0, request.light_level} >= 7'(SHADE_MAPS))
                     ? LIGHT_MAX : request.light_level;

    assign last      = pixels_left_reg <= 9'd1;
    assign texel_idx = {v_acc_reg[31:26], u_acc_reg[31:26]};

    always_comb
    begin
        case (column_reg[1:0])
            2'd1:    plane_off = PLANE_OFF_1;
            2'd2:    plane_off = PLANE_OFF_2;
            2'd3:    plane_off = PLANE_OFF_3;
            default: plane_off = 16'd0;
        endcase
    end

    always_comb
    begin
        u_acc_next       = u_acc_reg;
        v_acc_next       = v_acc_reg;
        column_next      = column_reg;
        pixels_left_next = pixels_left_reg;
        light_next       = light_reg;
        active_next      = active_reg;
        row_base_next    = row_base_reg;
        col_dbl_next     = col_dbl_reg;

        enq_valid        = 1'b0;
        enq_op.kind      = OP_PIXEL;
        enq_op.mem_addr  = request.load_addr;
        enq_op.data      = request.load_byte;
        enq_op.light     = light_reg;
        enq_op.pixel_addr = 16'd0;
        enq_op.last      = 1'b0;

        if (accept)
        begin
            case (cmd_t'(request.cmd))
                CMD_LOAD_TEXEL:
                begin
                    enq_op.kind = OP_TEX_WR;
                    enq_valid   = {1'b0, request.load_addr} < 15'(TEX_DEPTH);
                end
                CMD_LOAD_SHADE:
                begin
                    enq_op.kind = OP_SHADE_WR;
                    enq_valid   = {1'b0, request.load_addr} < 15'(SHADE_DEPTH);
                end
                CMD_BEGIN_SPAN:
                begin
                    if (bad_bounds)
                    begin
                        enq_op.kind      = OP_ERROR;
                        enq_valid        = 1'b1;
                        active_next      = 1'b0;
                        pixels_left_next = 9'd0;
                    end
                    else
                    begin
                        u_acc_next       = request.u_start;
                        v_acc_next       = request.v_start;
                        column_next      = (cols_dbl ? {2'b0, request.span_start, 1'b0}
                                                     : {3'b0, request.span_start})
                                         + {3'b0, window_left_reg};
                        pixels_left_next = request.span_end - request.span_start;
                        light_next       = light_sat;
                        active_next      = 1'b1;
                        row_base_next    = 16'(32'(frame_row) * 32'(ROW_BYTES));
                        col_dbl_next     = cols_dbl;
                    end
                end
                CMD_STEP_PIXEL:
                begin
                    if (active_reg)
                    begin
                        enq_valid         = 1'b1;
                        enq_op.kind       = OP_PIXEL;
                        enq_op.mem_addr   = {2'b0, texel_idx};
                        enq_op.pixel_addr = plane_off + row_base_reg + {6'b0, column_reg[11:2]};
                        enq_op.last       = last;
                        u_acc_next        = u_acc_reg + request.u_step;
                        v_acc_next        = v_acc_reg + request.v_step;
                        column_next       = column_reg + {10'b0, col_dbl_reg, !col_dbl_reg};
                        pixels_left_next  = last ? 9'd0 : pixels_left_reg - 9'd1;
                        active_next       = !last;
                    end
                end
                default:
                begin
                    enq_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detail_mode_reg  <= DETAIL_HIGH;
            window_left_reg  <= 9'd0;
            window_top_reg   <= 8'd0;
            view_columns_reg <= 9'd320;
            view_rows_reg    <= 8'd200;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_DETAIL_MODE:  detail_mode_reg  <= cfg_data[1:0];
                CFG_WINDOW_LEFT:  window_left_reg  <= cfg_data;
                CFG_WINDOW_TOP:   window_top_reg   <= cfg_data[7:0];
                CFG_VIEW_COLUMNS: view_columns_reg <= cfg_data;
                CFG_VIEW_ROWS:    view_rows_reg    <= cfg_data[7:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            u_acc_reg       <= 32'd0;
            v_acc_reg       <= 32'd0;
            column_reg      <= 12'd0;
            pixels_left_reg <= 9'd0;
            light_reg       <= 6'd0;
            active_reg      <= 1'b0;
            row_base_reg    <= 16'd0;
            col_dbl_reg     <= 1'b0;
        end
        else
        begin
            u_acc_reg       <= u_acc_next;
            v_acc_reg       <= v_acc_next;
            column_reg      <= column_next;
            pixels_left_reg <= pixels_left_next;
            light_reg       <= light_next;
            active_reg      <= active_next;
            row_base_reg    <= row_base_next;
            col_dbl_reg     <= col_dbl_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/trs_queue.sv -----
// ----------------------------------------------------------------------------
// trs_queue
// Short FIFO of classified work between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire trs_pkg::op_t  wr_op,
    input  wire logic          rd_en,
    output trs_pkg::op_t       rd_op,
    output trs_pkg::q_status_t status
);
    import trs_pkg::*;

    op_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic                do_wr, do_rd;

    assign status.full  = count_reg == (QUEUE_AW + 1)'(QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign do_wr        = wr_en && !status.full;
    assign do_rd        = rd_en && !status.empty;
    assign rd_op        = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW + 1)'(do_wr) - (QUEUE_AW + 1)'(do_rd);
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entry_reg[wr_ptr_reg] <= wr_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/trs_back.sv -----
// ----------------------------------------------------------------------------
// trs_back
// Texture and shade memories in a three-stage pipeline ending in the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module trs_back #(
    parameter int SHADE_MAPS = trs_pkg::SHADE_MAPS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire trs_pkg::op_t       q_op,
    input  wire trs_pkg::q_status_t q_status,
    output logic                    q_pop,
    input  wire logic               pop,
    output logic                    empty,
    output trs_pkg::result_t        result
);
    import trs_pkg::*;

    localparam int SHADE_DEPTH = SHADE_MAPS * 256;
    localparam int SHADE_AW    = $clog2(SHADE_DEPTH);

    logic [7:0] tex_mem   [TEX_DEPTH];
    logic [7:0] shade_mem [SHADE_DEPTH];

    logic        adv;
    logic        valid1_reg, valid2_reg, valid3_reg;
    op_t         op1_reg, op2_reg;
    logic [7:0]  texel_reg;
    logic [7:0]  shade_reg;
    logic        pixel3_reg;
    logic [15:0] addr3_reg;
    logic        last3_reg;
    logic        err3_reg;

    logic [TEX_AW-1:0]   tex_addr;
    logic [SHADE_AW-1:0] shade_wr_addr;
    logic [SHADE_AW-1:0] shade_rd_addr;

    // whole pipe moves unless the result register is held
    assign adv   = !valid3_reg || pop;
    assign q_pop = adv && !q_status.empty;

    assign tex_addr      = op1_reg.mem_addr[TEX_AW-1:0];
    assign shade_wr_addr = op2_reg.mem_addr[SHADE_AW-1:0];
    assign shade_rd_addr = SHADE_AW'({op2_reg.light, texel_reg});

    always_ff @(posedge clk)
    begin
        if (adv && valid1_reg)
        begin
            if (op1_reg.kind == OP_TEX_WR)
            begin
                tex_mem[tex_addr] <= op1_reg.data;
            end
            if (op1_reg.kind == OP_PIXEL)
            begin
                texel_reg <= tex_mem[tex_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid2_reg)
        begin
            if (op2_reg.kind == OP_SHADE_WR)
            begin
                shade_mem[shade_wr_addr] <= op2_reg.data;
            end
            if (op2_reg.kind == OP_PIXEL)
            begin
                shade_reg <= shade_mem[shade_rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg    <= q_op;
            op2_reg    <= op1_reg;
            pixel3_reg <= op2_reg.kind == OP_PIXEL;
            err3_reg   <= op2_reg.kind == OP_ERROR;
            addr3_reg  <= op2_reg.pixel_addr;
            last3_reg  <= op2_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid1_reg <= !q_status.empty;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg
                       && (op2_reg.kind == OP_PIXEL || op2_reg.kind == OP_ERROR);
        end
    end

    assign empty              = !valid3_reg;
    assign result.pixel_addr  = addr3_reg;
    assign result.pixel_value = pixel3_reg ? shade_reg : 8'd0;
    assign result.span_last   = last3_reg;
    assign result.span_error  = err3_reg;

endmodule

`default_nettype wire

// ----- rtl/textured_span_rasterizer.sv -----
// ----------------------------------------------------------------------------
// textured_span_rasterizer
// Affine textured floor span drawer for a four-plane byte framebuffer.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on request with push/full; an item is taken at a clock edge
//   with push high and full low. Load items fill the 64x64 texel store and
//   the shade map table, a begin item latches one span, and each step item
//   in an active span yields one pixel (planar byte address plus shaded
//   texel, span_last on the final one). A begin with bad bounds yields one
//   span_error item. Results leave on result with empty/pop, oldest first.
//   Path: an item taken is written to the work queue, then moves through
//   op1_reg, op2_reg and the result register. Throughput: one item per cycle
//   while results are popped; the front updates the span state as each item
//   is taken and the back streams the texture read then the shade read, each
//   one memory port per cycle. While a result waits and pop is low the
//   result register and the back pipeline hold; the front keeps taking items
//   until the four-entry work queue fills, then full rises.
//   Reset clears span state, config registers, queue and pipeline; the
//   texel and shade memories keep their contents and need no clearing pass.
//   Configuration (cfg_*) is written by the user while idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module textured_span_rasterizer #(
    parameter int PLANE_BYTES = trs_pkg::PLANE_BYTES_DEF,
    parameter int ROW_BYTES   = trs_pkg::ROW_BYTES_DEF,
    parameter int SHADE_MAPS  = trs_pkg::SHADE_MAPS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration write port
    input  wire logic              cfg_write,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [8:0]        cfg_data,
    // item input
    input  wire logic              push,
    output logic                   full,
    input  wire trs_pkg::request_t request,
    // result output
    output logic                   empty,
    input  wire logic              pop,
    output trs_pkg::result_t       result
);
    import trs_pkg::*;

    logic      enq_valid;
    op_t       enq_op;
    op_t       head_op;
    q_status_t q_status;
    logic      q_pop;

    // front: config, span stepping, classification into work ops
    trs_front #(
        .PLANE_BYTES (PLANE_BYTES),
        .ROW_BYTES   (ROW_BYTES),
        .SHADE_MAPS  (SHADE_MAPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .request   (request),
        .q_full    (q_status.full),
        .enq_valid (enq_valid),
        .enq_op    (enq_op)
    );

    // decouples the front from back-pressure on the result side
    trs_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (enq_valid),
        .wr_op  (enq_op),
        .rd_en  (q_pop),
        .rd_op  (head_op),
        .status (q_status)
    );

    // back: memory writes and reads in item order, result register
    trs_back #(
        .SHADE_MAPS (SHADE_MAPS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_op     (head_op),
        .q_status (q_status),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .result   (result)
    );

    assign full = q_status.full;

endmodule

`default_nettype wire

// ----- rtl/trs_checker.sv -----
// ----------------------------------------------------------------------------
// trs_checker
// Port-level checks for the textured span rasterizer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "textured_span_rasterizer_macros.svh"

module trs_checker (
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              push,
    input wire logic              full,
    input wire trs_pkg::request_t request,
    input wire logic              empty,
    input wire logic              pop,
    input wire trs_pkg::result_t  result
);
    import trs_pkg::*;

    logic in_take;
    logic out_hold;

    assign in_take  = push && !full && request.cmd == CMD_STEP_PIXEL;
    assign out_hold = !empty && !pop;

    // a waiting result stays put until taken
    `TRS_ASSERT_NEXT(a_result_held, out_hold, !empty && $stable(result))

    // an error item carries no pixel
    `TRS_ASSERT_NOW(a_error_clean, !empty && result.span_error,
        result.pixel_addr == 16'd0 && result.pixel_value == 8'd0 && !result.span_last)

    // the queue only fills when an item was taken (step or otherwise)
    `TRS_ASSERT_NEXT(a_full_cause, !(push && !full) && !in_take, !full || $past(full))

endmodule

bind textured_span_rasterizer trs_checker u_trs_checker (.*);

`default_nettype wire

// ----- test/textured_span_rasterizer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// textured_span_rasterizer_tb
// Self-checking bench for the textured span rasterizer. A queue of items,
// filled phase by phase from the main initial block, feeds a clocked driver.
// Each accepted item runs through a local span model that produces the
// expected framebuffer writes and error flags. A clocked monitor pops the
// results and compares them field by field. Config registers are rewritten
// between phases while the block is idle. Backpressure is random, plus one
// long receiver hold-off.
// ----------------------------------------------------------------------------

module textured_span_rasterizer_tb;

    import trs_pkg::*;

    // geometry of the default build
    localparam int SHADE_DEPTH = SHADE_MAPS_DEF * 256;

    // detail codes the package does not name
    localparam logic [1:0] DETAIL_MEDIUM = 2'd1;
    localparam logic [1:0] DETAIL_UNUSED = 2'd3;

    // pixels only read texel rows below TEX_ROWS, and texel bytes stay below
    // TEXEL_VALUES, so every read hits an entry loaded at the start
    localparam int TEX_ROWS     = 2;
    localparam int TEXEL_VALUES = 8;

    localparam int RANDOM_PER_SETTING = 100;
    localparam int HOLD_CYCLES        = 300;   // long receiver hold-off
    localparam int SETTLE_CYCLES      = 8;     // margin for trailing loads to drain
    localparam int STALL_LIMIT        = 5000;  // cycles with nothing moving on either side
    localparam int REPORT_MAX         = 10;

    // register settings per phase; phase 0 keeps the reset values
    int set_detail [6] = '{DETAIL_HIGH, DETAIL_LOW, DETAIL_UNUSED, DETAIL_MEDIUM,
                           DETAIL_HIGH, DETAIL_MEDIUM};
    int set_left   [6] = '{0, 319, 1, 201, 318, 0};
    int set_top    [6] = '{0, 199, 7, 50, 199, 0};
    int set_cols   [6] = '{320, 320, 1, 160, 319, 320};
    int set_rows   [6] = '{200, 200, 1, 100, 199, 200};

    // ------------------------------------------------------------------------
    // DUT ports, inputs all known from time zero
    // ------------------------------------------------------------------------
    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_write = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [8:0] cfg_data  = '0;
    logic       push      = 1'b0;
    logic       full;
    request_t   request   = '0;
    logic       empty;
    logic       pop       = 1'b0;
    result_t    result;

    textured_span_rasterizer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .request   (request),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Span model: its own copy of config and span state
    // ------------------------------------------------------------------------
    logic [1:0]  cfg_detail = DETAIL_HIGH;
    logic [8:0]  cfg_wleft  = '0;
    logic [7:0]  cfg_wtop   = '0;
    logic [8:0]  cfg_vcols  = 9'd320;
    logic [7:0]  cfg_vrows  = 8'd200;

    logic [7:0]  tex_mem   [TEX_DEPTH];
    logic [7:0]  shade_mem [SHADE_DEPTH];

    logic [31:0] u_acc      = '0;
    logic [31:0] v_acc      = '0;
    int unsigned span_col   = 0;   // framebuffer column, wraps at 16 bits
    int unsigned span_frow  = 0;   // framebuffer row after doubling and offset
    int unsigned span_cstep = 0;
    int unsigned span_left  = 0;
    int unsigned span_light = 0;
    logic        span_on    = 1'b0;

    // items waiting for the driver; the front one is on the bus while push
    request_t span_items [$];
    // expected framebuffer writes and error flags, oldest first
    result_t  fb_writes [$];

    int send_idle   = 20;   // percent of cycles the driver holds back
    int recv_idle   = 81;   // percent of cycles the monitor holds back
    int hold_asks   = 0;    // bumped by the main block to ask for a hold-off
    int mismatches  = 0;
    int checked     = 0;

    // one accepted item through the span model
    task automatic draw_item(input request_t rq);
        result_t     r;
        int unsigned spot, texel, sidx, plane, paddr, lt, row_i, start_i;
        logic        dbl_cols, dbl_rows, last;
        r = '0;
        case (rq.cmd)
            CMD_LOAD_TEXEL:
                if (rq.load_addr < TEX_DEPTH)
                    tex_mem[rq.load_addr] = rq.load_byte;
            CMD_LOAD_SHADE:
                if (rq.load_addr < SHADE_DEPTH)
                    shade_mem[rq.load_addr] = rq.load_byte;
            CMD_BEGIN_SPAN:
            begin
                dbl_cols = cfg_detail != DETAIL_HIGH;
                dbl_rows = cfg_detail >= DETAIL_LOW;
                // end may reach one past the view width
                if (int'(cfg_vcols) + 1 < int'(rq.span_end) ||
                    rq.span_end <= rq.span_start || cfg_vrows <= rq.span_row)
                begin
                    span_on = 1'b0;
                    span_left = 0;
                    r.span_error = 1'b1;
                    fb_writes.push_back(r);
                end
                else
                begin
                    lt = rq.light_level;
                    if (lt >= SHADE_MAPS_DEF)
                        lt = SHADE_MAPS_DEF - 1;
                    row_i = rq.span_row;
                    start_i = rq.span_start;
                    u_acc = rq.u_start;
                    v_acc = rq.v_start;
                    span_frow = (dbl_rows ? row_i * 2 : row_i) + cfg_wtop;
                    span_cstep = dbl_cols ? 2 : 1;
                    span_col = (dbl_cols ? start_i * 2 : start_i) + cfg_wleft;
                    span_left = int'(rq.span_end) - int'(rq.span_start);
                    span_light = lt;
                    span_on = 1'b1;
                end
            end
            CMD_STEP_PIXEL:
                if (span_on)
                begin
                    // texel row from v[31:26], column from u[31:26]
                    spot = ((v_acc >> 20) & 32'hfc0) + ((u_acc >> 26) & 32'h3f);
                    texel = tex_mem[spot % TEX_DEPTH];
                    sidx = span_light * 256 + texel;
                    r.pixel_value = (sidx < SHADE_DEPTH) ? shade_mem[sidx] : 8'h00;
                    plane = span_col & 3;
                    paddr = plane * PLANE_BYTES_DEF + span_frow * ROW_BYTES_DEF
                          + (span_col >> 2);
                    last = span_left <= 1;
                    r.pixel_addr = paddr[15:0];
                    r.span_last = last;
                    fb_writes.push_back(r);
                    u_acc = u_acc + rq.u_step;
                    v_acc = v_acc + rq.v_step;
                    span_col = (span_col + span_cstep) & 32'hffff;
                    if (last)
                    begin
                        span_left = 0;
                        span_on = 1'b0;
                    end
                    else
                        span_left = span_left - 1;
                end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Item builders; fields a command ignores get random junk
    // ------------------------------------------------------------------------
    function automatic request_t any_request();
        request_t rq;
        rq.cmd         = 2'($urandom);
        rq.load_addr   = 14'($urandom);
        rq.load_byte   = 8'($urandom);
        rq.span_start  = 9'($urandom);
        rq.span_end    = 9'($urandom);
        rq.span_row    = 8'($urandom);
        rq.u_start     = $urandom;
        rq.v_start     = $urandom;
        rq.u_step      = $urandom;
        rq.v_step      = $urandom;
        rq.light_level = 6'($urandom);
        return rq;
    endfunction

    function automatic request_t load_item(input cmd_t c, input int addr, input int val);
        request_t rq;
        rq = any_request();
        rq.cmd = c;
        rq.load_addr = 14'(addr);
        rq.load_byte = 8'(val);
        return rq;
    endfunction

    function automatic request_t begin_item(input int start, input int stop, input int row,
                                            input logic [31:0] u, input logic [31:0] v,
                                            input int light);
        request_t rq;
        rq = any_request();
        rq.cmd = CMD_BEGIN_SPAN;
        rq.span_start = 9'(start);
        rq.span_end = 9'(stop);
        rq.span_row = 8'(row);
        rq.u_start = u;
        rq.v_start = v;
        rq.light_level = 6'(light);
        return rq;
    endfunction

    function automatic request_t step_item(input logic [31:0] us, input logic [31:0] vs);
        request_t rq;
        rq = any_request();
        rq.cmd = CMD_STEP_PIXEL;
        rq.u_step = us;
        rq.v_step = vs;
        return rq;
    endfunction

    // random texture step: half of them small so the walk stays coherent
    function automatic logic [31:0] tex_step();
        if ($urandom_range(0, 1) == 0)
            return $urandom;
        return $urandom_range(0, 32'h0800_0000);
    endfunction

    // v start in a loaded texel row, fraction below half a row
    function automatic logic [31:0] row_start();
        return (32'($urandom_range(0, TEX_ROWS - 1)) << 26) | ($urandom & 32'h01ff_ffff);
    endfunction

    // v step small enough that a full span never leaves its texel row
    function automatic logic [31:0] row_step();
        return $urandom_range(0, 32'h0001_0000);
    endfunction

    // ------------------------------------------------------------------------
    // Driver: holds an item until taken, otherwise offers the next one
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && push && !full)
            draw_item(span_items.pop_front());
        if (!rst_n)
            push <= 1'b0;
        else if (push && full)
            ;   // stalled, keep the item on the bus
        else if (span_items.size() != 0 && $urandom_range(0, 99) >= send_idle)
        begin
            request <= span_items[0];
            push <= 1'b1;
        end
        else
            push <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Monitor: checks each popped item, then picks the next pop
    // ------------------------------------------------------------------------
    int hold_served = 0;
    int hold_left   = 0;

    task automatic note_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t: %s at item %0d: addr %h/%h value %h/%h last %b/%b error %b/%b",
                     $realtime, what, checked, want.pixel_addr, got.pixel_addr,
                     want.pixel_value, got.pixel_value, want.span_last, got.span_last,
                     want.span_error, got.span_error);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (fb_writes.size() == 0)
                note_mismatch("unexpected item (expected/actual)", '0, result);
            else
            begin
                want = fb_writes.pop_front();
                if (result.pixel_addr !== want.pixel_addr ||
                    result.pixel_value !== want.pixel_value ||
                    result.span_last !== want.span_last ||
                    result.span_error !== want.span_error)
                    note_mismatch("mismatch (expected/actual)", want, result);
            end
            checked++;
        end
        // hold-off is counted here so the sender keeps pushing meanwhile
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            pop <= 1'b0;
        end
        else if (hold_served != hold_asks)
        begin
            hold_served = hold_asks;
            hold_left = HOLD_CYCLES;
            pop <= 1'b0;
        end
        else
            pop <= rst_n && ($urandom_range(0, 99) >= recv_idle);
    end

    // ------------------------------------------------------------------------
    // Watchdog: too long without any item moving on either side
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((push && !full) || (pop && !empty))
                quiet = 0;
            else
                quiet++;
        end
        $display("textured_span_rasterizer regression: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Config writes and idle waits
    // ------------------------------------------------------------------------
    task automatic write_reg(input cfg_reg_t idx, input int val);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 9'(val);
        case (idx)
            CFG_DETAIL_MODE:  cfg_detail = 2'(val);
            CFG_WINDOW_LEFT:  cfg_wleft = 9'(val);
            CFG_WINDOW_TOP:   cfg_wtop = 8'(val);
            CFG_VIEW_COLUMNS: cfg_vcols = 9'(val);
            CFG_VIEW_ROWS:    cfg_vrows = 8'(val);
            default: ;
        endcase
    endtask

    // wait until everything sent has come back, then let loads drain
    task automatic settle();
        while (span_items.size() != 0 || push || fb_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int s, i, made, emax, hi, len, start, row, n, k, pick, light;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Load the texel rows that pixels read, and the shade entries of every
        // map for the texel bytes in use, so no pixel reads an unwritten entry.
        for (i = 0; i < TEX_ROWS * 64; i++)
            span_items.push_back(load_item(CMD_LOAD_TEXEL, i,
                                           $urandom_range(0, TEXEL_VALUES - 1)));
        for (i = 0; i < SHADE_MAPS_DEF; i++)
            for (k = 0; k < TEXEL_VALUES; k++)
                span_items.push_back(load_item(CMD_LOAD_SHADE, i * 256 + k,
                                               $urandom_range(0, 255)));

        // Directed: load address extremes, ignored loads, each bad-bound case,
        // stray steps, coordinate wrap, light saturation, end one past the
        // view, restart of an active span, and a bad begin stopping a span.
        span_items.push_back(load_item(CMD_LOAD_TEXEL, TEX_DEPTH - 1, 8'hff));
        span_items.push_back(load_item(CMD_LOAD_TEXEL, TEX_DEPTH, 8'h00));
        span_items.push_back(load_item(CMD_LOAD_TEXEL, 16383, 8'haa));
        span_items.push_back(load_item(CMD_LOAD_SHADE, SHADE_DEPTH - 1, 8'hff));
        span_items.push_back(load_item(CMD_LOAD_SHADE, SHADE_DEPTH, 8'h55));
        span_items.push_back(load_item(CMD_LOAD_SHADE, 0, 8'h00));
        span_items.push_back(step_item('1, '1));
        span_items.push_back(begin_item(0, 322, 0, '0, '0, 0));
        span_items.push_back(begin_item(100, 100, 10, '0, '0, 0));
        span_items.push_back(begin_item(319, 0, 10, '0, '0, 0));
        span_items.push_back(begin_item(0, 10, 200, '0, '0, 0));
        span_items.push_back(begin_item(0, 320, 199, '1, 32'h07ff_ffff, SHADE_MAPS_DEF - 1));
        span_items.push_back(step_item('1, '0));
        span_items.push_back(step_item('0, '0));
        span_items.push_back(step_item(32'h0400_0000, '0));
        span_items.push_back(begin_item(318, 321, 0, '0, 32'h0400_0000, 63));
        span_items.push_back(step_item(32'h0400_0000, 32'hfc00_0000));
        span_items.push_back(step_item(32'h0400_0000, 32'h0400_0000));
        span_items.push_back(step_item(32'h0400_0000, '0));
        span_items.push_back(step_item('1, '1));
        span_items.push_back(begin_item(5, 10, 0, $urandom, row_start(), 0));
        span_items.push_back(step_item($urandom, $urandom));
        span_items.push_back(begin_item(5, 10, 255, '0, '0, 0));
        span_items.push_back(step_item($urandom, $urandom));

        for (s = 0; s < 6; s++)
        begin
            if (s == 2)
            begin
                send_idle = 81;
                recv_idle = 20;
            end
            if (s == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (s > 0)
            begin
                settle();
                write_reg(CFG_DETAIL_MODE, set_detail[s]);
                write_reg(CFG_WINDOW_LEFT, set_left[s]);
                write_reg(CFG_WINDOW_TOP, set_top[s]);
                write_reg(CFG_VIEW_COLUMNS, set_cols[s]);
                write_reg(CFG_VIEW_ROWS, set_rows[s]);
                @(posedge clk);
                cfg_write <= 1'b0;
            end
            // sender runs flat out here, so the hold-off backs the block up
            if (s == 4)
                hold_asks++;

            made = 0;
            while (made < RANDOM_PER_SETTING)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    // well-formed span with random content, mostly short
                    emax = (int'(cfg_vcols) + 1 < 320) ? int'(cfg_vcols) + 1 : 320;
                    start = $urandom_range(0, emax - 1);
                    hi = emax - start;
                    if (hi > 8 && $urandom_range(0, 9) < 8)
                        len = $urandom_range(1, 8);
                    else
                        len = $urandom_range(1, hi);
                    row = $urandom_range(0, int'(cfg_vrows) - 1);
                    light = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 32)
                                                         : $urandom_range(33, 63);
                    span_items.push_back(begin_item(start, start + len, row,
                                                    $urandom, row_start(), light));
                    k = $urandom_range(0, 9);
                    n = len;
                    if (k == 0)
                        n = $urandom_range(0, len - 1);      // cut short, restarted next
                    else if (k == 1)
                        n = len + $urandom_range(1, 2);      // trailing stray steps
                    for (i = 0; i < n; i++)
                    begin
                        if ($urandom_range(0, 9) == 0)
                            span_items.push_back(load_item(CMD_LOAD_TEXEL,
                                $urandom_range(0, TEX_DEPTH - 1),
                                $urandom_range(0, TEXEL_VALUES - 1)));
                        span_items.push_back(step_item(tex_step(), row_step()));
                    end
                    made += 1 + n;
                end
                else if (pick < 80)
                begin
                    span_items.push_back(load_item(CMD_LOAD_TEXEL,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(TEX_DEPTH, 16383)
                                                    : $urandom_range(0, TEX_DEPTH - 1),
                        $urandom_range(0, TEXEL_VALUES - 1)));
                    made++;
                end
                else if (pick < 88)
                begin
                    span_items.push_back(load_item(CMD_LOAD_SHADE,
                        ($urandom_range(0, 9) == 0) ? $urandom_range(SHADE_DEPTH, 16383)
                                                    : $urandom_range(0, SHADE_DEPTH - 1),
                        $urandom_range(0, 255)));
                    made++;
                end
                else if (pick < 94)
                begin
                    // bad begin: past the view, empty or reversed, or row too low
                    k = $urandom_range(0, 2);
                    start = $urandom_range(0, 319);
                    if (k == 0)
                        span_items.push_back(begin_item(start,
                            $urandom_range(int'(cfg_vcols) + 2, 511), 0,
                            $urandom, $urandom, $urandom_range(0, 63)));
                    else if (k == 1)
                        span_items.push_back(begin_item(start, $urandom_range(0, start),
                            $urandom_range(0, 199), $urandom, $urandom,
                            $urandom_range(0, 63)));
                    else
                        span_items.push_back(begin_item(0, 1,
                            $urandom_range(int'(cfg_vrows), 255), $urandom, $urandom,
                            $urandom_range(0, 63)));
                    made++;
                end
                else
                    span_items.push_back(step_item($urandom, row_step()));
            end
        end

        settle();
        if (mismatches == 0 && fb_writes.size() == 0)
            $display("textured_span_rasterizer regression: pass");
        else
            $display("textured_span_rasterizer regression: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/trs_pkg.sv
rtl/trs_front.sv
rtl/trs_queue.sv
rtl/trs_back.sv
rtl/textured_span_rasterizer.sv
rtl/trs_checker.sv
test/textured_span_rasterizer_tb.sv
